// ----- rtl/pvtd_pkg.sv -----
package pvtd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int PC_W    = 64;
    localparam int VALUE_W = 32;
    localparam int GROUP_W = 7;
    localparam int BYTE_W  = 8;

    localparam logic [2:0] LAST_GROUP = 3'd4;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NO_TABLE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_TABLE = 2'd2;

    localparam logic       OP_START = 1'b0;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_START_EMPTY,
        KIND_BYTE
    } item_kind_t;

    typedef struct packed {
        item_kind_t           kind;
        logic [GROUP_W-1:0]   group;
        logic                 more;
        logic [PC_W-1:0]      entry_pc;
        logic [PC_W-1:0]      target_pc;
    } pvtd_item_t;

endpackage

// ----- rtl/pvtd_front.sv -----
module pvtd_front #(
    parameter int QUEUE_DEPTH = pvtd_pkg::QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [7:0]                s_table_byte,
    input  logic [63:0]               s_entry_pc,
    input  logic [63:0]               s_target_pc,
    input  logic                      s_table_present,
    output logic                      q_valid,
    input  logic                      q_pop,
    output pvtd_pkg::pvtd_item_t      q_item
);
    import pvtd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    pvtd_item_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    pvtd_item_t          item;
    logic                push;
    logic                pop;

    // classify the incoming request
    always_comb begin
        item.group     = s_table_byte[GROUP_W-1:0];
        item.more      = s_table_byte[BYTE_W-1];
        item.entry_pc  = s_entry_pc;
        item.target_pc = s_target_pc;
        if (s_op != OP_START) begin
            item.kind = KIND_BYTE;
        end else if (s_table_present) begin
            item.kind = KIND_START;
        end else begin
            item.kind = KIND_START_EMPTY;
        end
    end

    assign s_ready = (count_reg != FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- rtl/pvtd_back.sv -----
module pvtd_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                pc_shift,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  pvtd_pkg::pvtd_item_t      q_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [31:0]               m_value,
    output logic [1:0]                m_status
);
    import pvtd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 rd_pc_reg, rd_pc_next;
    logic [VALUE_W-1:0]   accum_reg, accum_next;
    logic [2:0]           group_idx_reg, group_idx_next;
    logic [VALUE_W-1:0]   held_delta_reg, held_delta_next;
    logic [VALUE_W-1:0]   run_value_reg, run_value_next;
    logic [PC_W-1:0]      run_pc_reg, run_pc_next;
    logic [PC_W-1:0]      entry_reg, entry_next;
    logic [PC_W-1:0]      target_reg, target_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [1:0]           out_status_reg, out_status_next;

    logic                 go;
    logic                 emit;
    logic [VALUE_W-1:0]   placed;
    logic [VALUE_W-1:0]   varint;
    logic [VALUE_W-1:0]   pc_delta;
    logic [VALUE_W-1:0]   value_sum;
    logic [PC_W-1:0]      pc_sum;

    assign go    = q_valid && (!out_valid_reg || m_ready);
    assign q_pop = go;

    always_comb begin
        unique case (group_idx_reg)
            3'd0:    placed = {25'd0, q_item.group};
            3'd1:    placed = {18'd0, q_item.group, 7'd0};
            3'd2:    placed = {11'd0, q_item.group, 14'd0};
            3'd3:    placed = {4'd0, q_item.group, 21'd0};
            default: placed = {q_item.group[3:0], 28'd0};
        endcase
    end

    assign varint    = accum_reg | placed;
    assign pc_delta  = varint << pc_shift;
    assign value_sum = run_value_reg + held_delta_reg;
    assign pc_sum    = run_pc_reg + {32'd0, pc_delta};

    always_comb begin
        busy_next       = busy_reg;
        rd_pc_next      = rd_pc_reg;
        accum_next      = accum_reg;
        group_idx_next  = group_idx_reg;
        held_delta_next = held_delta_reg;
        run_value_next  = run_value_reg;
        run_pc_next     = run_pc_reg;
        entry_next      = entry_reg;
        target_next     = target_reg;
        emit            = 1'b0;
        out_value_next  = '1;
        out_status_next = STATUS_BAD_TABLE;
        if (go) begin
            unique case (q_item.kind)
                KIND_START, KIND_START_EMPTY: begin
                    rd_pc_next      = 1'b0;
                    accum_next      = '0;
                    group_idx_next  = '0;
                    held_delta_next = '0;
                    run_value_next  = '1;
                    entry_next      = q_item.entry_pc;
                    target_next     = q_item.target_pc;
                    run_pc_next     = q_item.entry_pc;
                    busy_next       = (q_item.kind == KIND_START);
                    if (q_item.kind == KIND_START_EMPTY) begin
                        emit            = 1'b1;
                        out_status_next = STATUS_NO_TABLE;
                    end
                end
                KIND_BYTE: begin
                    if (busy_reg) begin
                        if (q_item.more) begin
                            accum_next = varint;
                            if (group_idx_reg == LAST_GROUP) begin
                                emit      = 1'b1;
                                busy_next = 1'b0;
                            end else begin
                                group_idx_next = group_idx_reg + 1'b1;
                            end
                        end else begin
                            accum_next     = '0;
                            group_idx_next = '0;
                            if (!rd_pc_reg) begin
                                if (varint == '0 && run_pc_reg != entry_reg) begin
                                    emit      = 1'b1;
                                    busy_next = 1'b0;
                                end else begin
                                    // zig-zag decode
                                    held_delta_next = varint[0] ? ~(varint >> 1)
                                                                : (varint >> 1);
                                    rd_pc_next      = 1'b1;
                                end
                            end else begin
                                rd_pc_next     = 1'b0;
                                run_value_next = value_sum;
                                run_pc_next    = pc_sum;
                                if (target_reg < pc_sum) begin
                                    emit            = 1'b1;
                                    busy_next       = 1'b0;
                                    out_value_next  = value_sum;
                                    out_status_next = STATUS_FOUND;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            rd_pc_reg      <= 1'b0;
            accum_reg      <= '0;
            group_idx_reg  <= '0;
            held_delta_reg <= '0;
            run_value_reg  <= '1;
            run_pc_reg     <= '0;
            entry_reg      <= '0;
            target_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            rd_pc_reg      <= rd_pc_next;
            accum_reg      <= accum_next;
            group_idx_reg  <= group_idx_next;
            held_delta_reg <= held_delta_next;
            run_value_reg  <= run_value_next;
            run_pc_reg     <= run_pc_next;
            entry_reg      <= entry_next;
            target_reg     <= target_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

endmodule

// ----- rtl/pc_value_table_decoder.sv -----
// channel   | ports                                   | direction
// ----------+-----------------------------------------+----------
// request   | s_valid s_ready s_op s_table_byte       | in
//           | s_entry_pc s_target_pc s_table_present  |
// result    | m_valid m_ready m_value m_status        | out
// config    | cfg_wr_en cfg_wr_data (pc_shift)        | in
//
// One request per cycle sustained while the result is not stalled; each table
// byte is resolved by the back end's accumulate, add and compare path.
// Taken requests are queued; the back end pops them and registers the result.
// Reset is synchronous; the queue empties and the decoder goes idle.
// A stalled result blocks the back end only; the queue keeps taking requests
// until it is full.
module pc_value_table_decoder #(
    parameter int QUEUE_DEPTH = pvtd_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_op,
    input  logic [7:0]   s_table_byte,
    input  logic [63:0]  s_entry_pc,
    input  logic [63:0]  s_target_pc,
    input  logic         s_table_present,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [31:0]  m_value,
    output logic [1:0]   m_status
);
    import pvtd_pkg::*;

    logic [1:0]   pc_shift_reg;
    logic         q_valid;
    logic         q_pop;
    pvtd_item_t   q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_shift_reg <= '0;
        end else if (cfg_wr_en) begin
            pc_shift_reg <= cfg_wr_data;
        end
    end

    pvtd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_table_byte    (s_table_byte),
        .s_entry_pc      (s_entry_pc),
        .s_target_pc     (s_target_pc),
        .s_table_present (s_table_present),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_item          (q_item)
    );

    pvtd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pc_shift (pc_shift_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

endmodule
